[hdl/assert_macros.svh]
// assertion macros shared by the clipper rtl
// depends on nothing; users provide clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CPC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define CPC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[hdl/cpc_pkg.sv]
// types, constants and helpers of the polygon plane clipper
// depends on nothing
package cpc_pkg;

	localparam int COORD_BITS = 32;
	localparam int DIST_BITS  = 64;
	localparam int THR_BITS   = 40;
	localparam int CFG_BITS   = 40;
	localparam int LAM_BITS   = 33;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIST_BITS-1:0]  dist_t;

	typedef enum logic [1:0] {
		SIDE_ON    = 2'd0,
		SIDE_FRONT = 2'd1,
		SIDE_BACK  = 2'd2
	} side_t;

	typedef enum logic [2:0] {
		CFG_NORMAL_X  = 3'd0,
		CFG_NORMAL_Y  = 3'd1,
		CFG_NORMAL_Z  = 3'd2,
		CFG_POINT_X   = 3'd3,
		CFG_POINT_Y   = 3'd4,
		CFG_POINT_Z   = 3'd5,
		CFG_THRESHOLD = 3'd6
	} cfg_index_t;

	typedef enum logic [2:0] {
		X_IDLE, X_NORM, X_DIV, X_MUL, X_ADD, X_DONE
	} xstate_t;

	typedef enum logic [1:0] {
		B_IDLE, B_RUN, B_WAIT
	} bstate_t;

	typedef struct packed {
		coord_t vert_x;
		coord_t vert_y;
		coord_t vert_z;
		logic   final_vertex;
	} vertex_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
		logic   is_crossing;
		logic   has_vertex;
		logic   polygon_end;
	} result_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} xyz_t;

	// classified vertex, as queued between front and back
	typedef struct packed {
		xyz_t  pos;
		dist_t sdist;
		side_t side;
		logic  last;
	} point_t;

	typedef struct packed {
		logic   valid;
		point_t item;
	} link_t;

	typedef struct packed {
		coord_t normal_x;
		coord_t normal_y;
		coord_t normal_z;
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
		logic [THR_BITS-1:0] threshold;
	} plane_t;

	function automatic logic [DIST_BITS-1:0] mag_dist(dist_t d);
		return d[DIST_BITS-1] ? DIST_BITS'(-d) : DIST_BITS'(d);
	endfunction

	function automatic logic opposite(side_t a, side_t b);
		return (a != SIDE_ON) && (b != SIDE_ON) && (a != b);
	endfunction

endpackage

[hdl/cpc_cross.sv]
// crossing point unit: normalize, restoring divide, then one multiply per axis
// depends on cpc_pkg
module cpc_cross import cpc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  point_t a,
	input  point_t b,
	input  logic   ack,
	output logic   valid,
	output xyz_t   pt
);

	localparam logic [64:0] ROUND_HALF = 65'd1 << 31;

	xstate_t state_q, state_d;

	logic [DIST_BITS-1:0] num_q, den_q;
	logic [31:0]          div_q, rem_q;
	logic [LAM_BITS-1:0]  lam_q;
	logic [4:0]           cnt_q;
	logic [1:0]           idx_q;
	coord_t               a_q [3];
	coord_t               b_q [3];
	coord_t               res_q [3];
	logic [63:0]          prod_q;
	logic                 neg_q;
	coord_t               base_q;

	logic [31:0] den_use;
	logic        q_top;
	logic [32:0] rsh;
	logic        q_bit;
	logic signed [32:0] e;
	logic [31:0] e_mag;
	logic [64:0] prod_full;
	logic [64:0] rnd;
	logic [31:0] r;
	coord_t      c;

	always_comb begin
		den_use   = (den_q[31:0] == 32'd0) ? 32'd1 : den_q[31:0];
		q_top     = num_q[31:0] >= den_use;
		rsh       = {rem_q, 1'b0};
		q_bit     = rsh >= {1'b0, div_q};
		e         = 33'(b_q[idx_q]) - 33'(a_q[idx_q]);
		e_mag     = e[32] ? 32'(-e) : 32'(e);
		prod_full = 65'(e_mag) * 65'(lam_q);
		rnd       = 65'(prod_q) + ROUND_HALF;
		r         = rnd[63:32];
		c         = neg_q ? base_q - r : base_q + r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= X_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		valid   = 1'b0;
		unique case (state_q)
			X_IDLE: if (start) state_d = X_NORM;
			X_NORM: if (den_q[63:32] == 32'd0) state_d = X_DIV;
			X_DIV:  if (cnt_q == 5'd0) state_d = X_MUL;
			X_MUL:  state_d = X_ADD;
			X_ADD:  state_d = (idx_q == 2'd2) ? X_DONE : X_MUL;
			X_DONE: begin
				valid = 1'b1;
				if (ack) state_d = X_IDLE;
			end
			default: state_d = X_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			X_IDLE: if (start) begin
				num_q  <= mag_dist(a.sdist);
				den_q  <= mag_dist(a.sdist) + mag_dist(b.sdist);
				a_q[0] <= a.pos.x;
				a_q[1] <= a.pos.y;
				a_q[2] <= a.pos.z;
				b_q[0] <= b.pos.x;
				b_q[1] <= b.pos.y;
				b_q[2] <= b.pos.z;
			end
			X_NORM: begin
				if (den_q[63:32] != 32'd0) begin
					num_q <= num_q >> 1;
					den_q <= den_q >> 1;
				end else begin
					div_q <= den_use;
					lam_q <= {32'd0, q_top};
					rem_q <= q_top ? num_q[31:0] - den_use : num_q[31:0];
					cnt_q <= 5'd31;
				end
			end
			X_DIV: begin
				rem_q <= q_bit ? 32'(rsh - {1'b0, div_q}) : rsh[31:0];
				lam_q <= {lam_q[31:0], q_bit};
				cnt_q <= cnt_q - 5'd1;
				idx_q <= 2'd0;
			end
			X_MUL: begin
				prod_q <= prod_full[63:0];
				neg_q  <= e[32];
				base_q <= a_q[idx_q];
			end
			X_ADD: begin
				res_q[idx_q] <= c;
				idx_q        <= idx_q + 2'd1;
			end
			X_DONE: ;
			default: ;
		endcase
	end

	assign pt.x = res_q[0];
	assign pt.y = res_q[1];
	assign pt.z = res_q[2];

endmodule

[hdl/cpc_front.sv]
// front part: signed distance of each vertex, side class, and a two-entry queue
// depends on cpc_pkg
module cpc_front import cpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  vertex_t vertex,
	input  plane_t  plane,
	input  logic    deq,
	output logic    full,
	output link_t   link
);

	logic              v_s1, v_s2, v_s3;
	vertex_t           vert_s1, vert_s2, vert_s3;
	logic signed [32:0] diff_s1 [3];
	logic signed [64:0] prod_s2 [3];
	dist_t             dist_s3;

	point_t     mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	logic               accept;
	logic signed [66:0] sum;
	dist_t              dist_sat;
	logic signed [64:0] d_ext, thr_ext;
	point_t             cls;

	assign full   = v_s1 | v_s2 | v_s3 | (cnt_q == 2'd2);
	assign accept = push & ~full;

	always_comb begin
		sum = 67'(prod_s2[0]) + 67'(prod_s2[1]) + 67'(prod_s2[2]);
		// saturate to 64 bits
		if (sum[66:63] == 4'b0000 || sum[66:63] == 4'b1111) begin
			dist_sat = sum[63:0];
		end else if (sum[66]) begin
			dist_sat = {1'b1, 63'd0};
		end else begin
			dist_sat = {1'b0, {63{1'b1}}};
		end
		d_ext    = 65'(dist_s3);
		thr_ext  = $signed({25'd0, plane.threshold});
		cls.pos.x = vert_s3.vert_x;
		cls.pos.y = vert_s3.vert_y;
		cls.pos.z = vert_s3.vert_z;
		cls.sdist = dist_s3;
		cls.last  = vert_s3.final_vertex;
		if (d_ext > thr_ext) begin
			cls.side = SIDE_FRONT;
		end else if (d_ext < -thr_ext) begin
			cls.side = SIDE_BACK;
		end else begin
			cls.side = SIDE_ON;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) wr_q <= ~wr_q;
			if (deq) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(v_s3) - 2'(deq);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vert_s1    <= vertex;
			diff_s1[0] <= 33'(vertex.vert_x) - 33'(plane.point_x);
			diff_s1[1] <= 33'(vertex.vert_y) - 33'(plane.point_y);
			diff_s1[2] <= 33'(vertex.vert_z) - 33'(plane.point_z);
		end
		vert_s2    <= vert_s1;
		prod_s2[0] <= diff_s1[0] * plane.normal_x;
		prod_s2[1] <= diff_s1[1] * plane.normal_y;
		prod_s2[2] <= diff_s1[2] * plane.normal_z;
		vert_s3    <= vert_s2;
		dist_s3    <= dist_sat;
		if (v_s3) mem_q[wr_q] <= cls;
	end

	assign link.valid = cnt_q != 2'd0;
	assign link.item  = mem_q[rd_q];

endmodule

[hdl/cpc_back.sv]
// back part: edge sequencer, crossing unit and four-entry result queue
// depends on cpc_pkg and cpc_cross
module cpc_back import cpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  link_t   link,
	output logic    deq,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	bstate_t state_q, state_d;

	point_t     cur_q, prev_q, first_q;
	logic       in_poly_q;
	logic [4:0] pend_q, pend_new;
	logic       fin_q;

	result_t    fifo_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	logic [4:0] low;
	logic       last;
	logic       out_full;
	logic       do_push, do_pop, clear, commit;
	result_t    push_data;
	logic       x_start, x_ack, x_valid;
	point_t     x_a, x_b;
	xyz_t       x_pt;

	cpc_cross u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (x_start),
		.a      (x_a),
		.b      (x_b),
		.ack    (x_ack),
		.valid  (x_valid),
		.pt     (x_pt)
	);

	// pending steps: prev vertex, crossing prev-cur, cur vertex,
	// crossing cur-first, empty close
	always_comb begin
		pend_new[0] = in_poly_q & (prev_q.side != SIDE_BACK);
		pend_new[1] = in_poly_q & opposite(prev_q.side, link.item.side);
		pend_new[2] = link.item.last & (link.item.side != SIDE_BACK);
		pend_new[3] = link.item.last & in_poly_q & opposite(link.item.side, first_q.side);
		pend_new[4] = link.item.last & ~|pend_new[3:0];
	end

	always_comb begin
		low      = pend_q & (~pend_q + 5'd1);
		last     = (pend_q & ~low) == 5'd0;
		out_full = cnt_q == 3'd4;
		x_a      = low[1] ? prev_q : cur_q;
		x_b      = low[1] ? cur_q : (in_poly_q ? first_q : cur_q);

		push_data.is_crossing = 1'b0;
		push_data.has_vertex  = 1'b1;
		push_data.polygon_end = fin_q & last;
		if (low[0]) begin
			push_data.out_x = prev_q.pos.x;
			push_data.out_y = prev_q.pos.y;
			push_data.out_z = prev_q.pos.z;
		end else if (low[4]) begin
			push_data.out_x      = '0;
			push_data.out_y      = '0;
			push_data.out_z      = '0;
			push_data.has_vertex = 1'b0;
		end else if (state_q == B_WAIT) begin
			push_data.out_x       = x_pt.x;
			push_data.out_y       = x_pt.y;
			push_data.out_z       = x_pt.z;
			push_data.is_crossing = 1'b1;
		end else begin
			push_data.out_x = cur_q.pos.x;
			push_data.out_y = cur_q.pos.y;
			push_data.out_z = cur_q.pos.z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		deq     = 1'b0;
		do_push = 1'b0;
		clear   = 1'b0;
		commit  = 1'b0;
		x_start = 1'b0;
		x_ack   = 1'b0;
		unique case (state_q)
			B_IDLE: if (link.valid) begin
				deq     = 1'b1;
				state_d = B_RUN;
			end
			B_RUN: begin
				if (pend_q == 5'd0) begin
					commit  = 1'b1;
					state_d = B_IDLE;
				end else if (low[1] | low[3]) begin
					x_start = 1'b1;
					state_d = B_WAIT;
				end else if (!out_full) begin
					do_push = 1'b1;
					clear   = 1'b1;
				end
			end
			B_WAIT: if (x_valid && !out_full) begin
				do_push = 1'b1;
				clear   = 1'b1;
				x_ack   = 1'b1;
				state_d = B_RUN;
			end
			default: state_d = B_IDLE;
		endcase
	end

	assign do_pop = pop & (cnt_q != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_poly_q <= 1'b0;
			pend_q    <= 5'd0;
			fin_q     <= 1'b0;
			prev_q    <= '0;
			first_q   <= '0;
			wr_q      <= 2'd0;
			rd_q      <= 2'd0;
			cnt_q     <= 3'd0;
		end else begin
			if (deq) begin
				pend_q <= pend_new;
				fin_q  <= link.item.last;
			end else if (clear) begin
				pend_q <= pend_q & ~low;
			end
			if (commit) begin
				prev_q    <= cur_q;
				in_poly_q <= ~cur_q.last;
				if (!in_poly_q) first_q <= cur_q;
			end
			if (do_push) wr_q <= wr_q + 2'd1;
			if (do_pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(do_push) - 3'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (deq) cur_q <= link.item;
		if (do_push) fifo_q[wr_q] <= push_data;
	end

	assign empty  = cnt_q == 3'd0;
	assign result = fifo_q[rd_q];

endmodule

[hdl/convex_polygon_plane_clipper_top.sv]
// convex polygon clipper against one plane, plane registers, front and back parts
// a vertex goes through registers s1, s2 and s3 into the front queue, then the back
// walks its steps; each crossing runs normalize, divide and multiply in cpc_cross
// the front holds one vertex in flight, and a busy crossing unit stalls the back
// reset: asynchronous, active low; plane is z = 0 with normal +z, band 429497
// depends on cpc_pkg, cpc_front, cpc_back and assert_macros.svh
`include "assert_macros.svh"

module convex_polygon_plane_clipper_top import cpc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// vertex side
	input  logic                push,
	output logic                full,
	input  vertex_t             vertex,
	// result side
	output logic                empty,
	input  logic                pop,
	output result_t             result,
	// register writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data
);

	// plane registers: write only while the block is idle (the block does not enforce it)
	plane_t plane_q;

	// classified vertices from front to back
	link_t link;
	logic  deq;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q.normal_x  <= '0;
			plane_q.normal_y  <= '0;
			plane_q.normal_z  <= coord_t'(65536);
			plane_q.point_x   <= '0;
			plane_q.point_y   <= '0;
			plane_q.point_z   <= '0;
			plane_q.threshold <= THR_BITS'(429497);
		end else if (cfg_valid) begin
			// an index past the list is dropped
			unique case (cfg_index)
				CFG_NORMAL_X:  plane_q.normal_x  <= cfg_data[COORD_BITS-1:0];
				CFG_NORMAL_Y:  plane_q.normal_y  <= cfg_data[COORD_BITS-1:0];
				CFG_NORMAL_Z:  plane_q.normal_z  <= cfg_data[COORD_BITS-1:0];
				CFG_POINT_X:   plane_q.point_x   <= cfg_data[COORD_BITS-1:0];
				CFG_POINT_Y:   plane_q.point_y   <= cfg_data[COORD_BITS-1:0];
				CFG_POINT_Z:   plane_q.point_z   <= cfg_data[COORD_BITS-1:0];
				CFG_THRESHOLD: plane_q.threshold <= cfg_data[THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// front: distance to the plane and side class, one vertex in flight
	cpc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.vertex (vertex),
		.plane  (plane_q),
		.deq    (deq),
		.full   (full),
		.link   (link)
	);

	// back: walks the edges, computes crossings, queues results
	cpc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.link   (link),
		.deq    (deq),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	// the back never takes from an empty queue
	`CPC_ASSERT_IMP(a_deq_valid, deq, link.valid, "dequeue from empty queue")
	// a vertex just taken keeps the front busy
	`CPC_ASSERT_NXT(a_one_in_flight, push && !full, full, "front took two vertices")
	// a waiting result does not vanish unless taken
	`CPC_ASSERT_NXT(a_result_holds, !empty && !pop, !empty, "waiting result lost")
	// an empty close always ends the polygon and is no crossing
	`CPC_ASSERT_IMP(a_empty_close, !empty && !result.has_vertex,
		result.polygon_end && !result.is_crossing, "bad empty close")

endmodule
